FILE: design/vled_pkg.sv
// ----------------------------------------------------------------------------
// Voltage LED meter package
// Shared widths, the colour types and the gamma-2.8 table for the meter
// display pipeline.
// ----------------------------------------------------------------------------
package vled_pkg;

   // Field widths of the request and the response.
   localparam int ReadingWidth = 14;
   localparam int DigitWidth   = 4;
   localparam int ColourWidth  = 8;

   // Number of register stages from request to response.
   localparam int PipeDepth = 6;

   // Ramp arithmetic: offset into a segment, product of offset and slope,
   // and the reciprocal used to divide by the segment span.
   localparam int OffsetWidth = 11;
   localparam int NumWidth    = 17;
   localparam int RecipShift  = 18;
   localparam int RecipWidth  = 14;
   localparam int ProdWidth   = NumWidth + RecipWidth;
   localparam int QuotWidth   = ProdWidth - RecipShift;
   localparam int QdWidth     = QuotWidth + OffsetWidth;

   // Segment spans of the colour ramp and their reciprocals.
   localparam logic [OffsetWidth-1:0] Span500  = OffsetWidth'(500);
   localparam logic [OffsetWidth-1:0] Span1400 = OffsetWidth'(1400);
   localparam logic [OffsetWidth-1:0] Span70   = OffsetWidth'(70);
   localparam logic [OffsetWidth-1:0] Span20   = OffsetWidth'(20);
   localparam logic [OffsetWidth-1:0] Span110  = OffsetWidth'(110);

   localparam logic [RecipWidth-1:0] Recip500  = RecipWidth'((1 << RecipShift) / 500);
   localparam logic [RecipWidth-1:0] Recip1400 = RecipWidth'((1 << RecipShift) / 1400);
   localparam logic [RecipWidth-1:0] Recip70   = RecipWidth'((1 << RecipShift) / 70);
   localparam logic [RecipWidth-1:0] Recip20   = RecipWidth'((1 << RecipShift) / 20);
   localparam logic [RecipWidth-1:0] Recip110  = RecipWidth'((1 << RecipShift) / 110);

   // One colour triple.
   typedef struct packed {
      logic [ColourWidth-1:0] red;
      logic [ColourWidth-1:0] green;
      logic [ColourWidth-1:0] blue;
   } rgb_type;

   // Line of one channel within a segment: base plus or minus a slope.
   typedef struct packed {
      logic [ColourWidth-1:0] base;
      logic [ColourWidth-1:0] step;
      logic                   neg;
   } chan_cfg_type;

   // Gamma 2.8 table, round(255*(x/255)^2.8).
   localparam logic [7:0] Gamma28 [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
      8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
      8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
      8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
      8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
      8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
      8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
      8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
      8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
      8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
      8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
      8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
      8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
      8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
      8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
      8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
      8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
      8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
      8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
   };

endpackage

FILE: design/vled_digits.sv
// ----------------------------------------------------------------------------
// Voltage LED meter digit splitter
// Saturates the reading to four decimal digits, takes off thousands, then
// hundreds, then tens and ones together, and marks leading zeros for blanking.
// ----------------------------------------------------------------------------
module vled_digits
   import vled_pkg::*;
(
   input  logic                    clock,
   input  logic                    advance,
   input  logic [ReadingWidth-1:0] reading,
   output logic [DigitWidth-1:0]   digit_thousands,
   output logic [DigitWidth-1:0]   digit_hundreds,
   output logic [DigitWidth-1:0]   digit_tens,
   output logic [DigitWidth-1:0]   digit_ones,
   output logic [DigitWidth-1:0]   blank_mask
);

   localparam logic [ReadingWidth-1:0] MaxReading = ReadingWidth'(9999);

   // Digit of a value below ten times the place, by a set of compares.
   function automatic logic [DigitWidth-1:0] digit_of(input logic [ReadingWidth-1:0] value,
                                                      input logic [ReadingWidth-1:0] place);
      logic [DigitWidth-1:0] digit;
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         if (value >= ReadingWidth'(k) * place) begin
            digit = DigitWidth'(k);
         end
      end
      return digit;
   endfunction

   logic [ReadingWidth-1:0] rest1_ff, rest1_in;
   logic [9:0]              rest2_ff, rest2_in;
   logic [DigitWidth-1:0]   thou2_ff, thou2_in;
   logic [6:0]              rest3_ff, rest3_in;
   logic [DigitWidth-1:0]   thou3_ff, hund3_ff, hund3_in;
   logic [DigitWidth-1:0]   thou4_ff, hund4_ff, tens4_ff, tens4_in, ones4_ff, ones4_in;
   logic [DigitWidth-1:0]   thou5_ff, hund5_ff, tens5_ff, ones5_ff, mask5_ff, mask5_in;
   logic [DigitWidth-1:0]   thou6_ff, hund6_ff, tens6_ff, ones6_ff, mask6_ff;

   // Stage logic: saturate, then peel off thousands, hundreds and tens.
   always_comb begin
      logic [ReadingWidth-1:0] prod;
      rest1_in = (reading > MaxReading) ? MaxReading : reading;

      thou2_in = digit_of(rest1_ff, ReadingWidth'(1000));
      prod     = ReadingWidth'(thou2_in) * ReadingWidth'(1000);
      rest2_in = 10'(rest1_ff - prod);

      hund3_in = digit_of(ReadingWidth'(rest2_ff), ReadingWidth'(100));
      prod     = ReadingWidth'(hund3_in) * ReadingWidth'(100);
      rest3_in = 7'(ReadingWidth'(rest2_ff) - prod);

      tens4_in = digit_of(ReadingWidth'(rest3_ff), ReadingWidth'(10));
      prod     = ReadingWidth'(tens4_in) * ReadingWidth'(10);
      ones4_in = DigitWidth'(ReadingWidth'(rest3_ff) - prod);

      mask5_in[3] = (thou4_ff == '0);
      mask5_in[2] = mask5_in[3] && (hund4_ff == '0);
      mask5_in[1] = mask5_in[2] && (tens4_ff == '0);
      mask5_in[0] = mask5_in[1] && (ones4_ff == '0);
   end

   // Pipeline registers, moved together whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         rest1_ff <= rest1_in;
         rest2_ff <= rest2_in;
         thou2_ff <= thou2_in;
         rest3_ff <= rest3_in;
         thou3_ff <= thou2_ff;
         hund3_ff <= hund3_in;
         thou4_ff <= thou3_ff;
         hund4_ff <= hund3_ff;
         tens4_ff <= tens4_in;
         ones4_ff <= ones4_in;
         thou5_ff <= thou4_ff;
         hund5_ff <= hund4_ff;
         tens5_ff <= tens4_ff;
         ones5_ff <= ones4_ff;
         mask5_ff <= mask5_in;
         thou6_ff <= thou5_ff;
         hund6_ff <= hund5_ff;
         tens6_ff <= tens5_ff;
         ones6_ff <= ones5_ff;
         mask6_ff <= mask5_ff;
      end
   end

   assign digit_thousands = thou6_ff;
   assign digit_hundreds  = hund6_ff;
   assign digit_tens      = tens6_ff;
   assign digit_ones      = ones6_ff;
   assign blank_mask      = mask6_ff;

endmodule

FILE: design/vled_ramp.sv
// ----------------------------------------------------------------------------
// Voltage LED meter colour ramp
// Piecewise-linear colour ramp over five register stages: segment pick,
// slope multiply, reciprocal multiply, back-multiply, then correction,
// sign, base and clamp.
// ----------------------------------------------------------------------------
module vled_ramp
   import vled_pkg::*;
(
   input  logic                    clock,
   input  logic                    advance,
   input  logic [ReadingWidth-1:0] reading,
   output rgb_type                 colour
);

   localparam int Chans = 3;

   function automatic chan_cfg_type chan(input logic [ColourWidth-1:0] base,
                                         input logic [ColourWidth-1:0] step,
                                         input logic neg);
      chan_cfg_type c;
      c.base = base;
      c.step = step;
      c.neg  = neg;
      return c;
   endfunction

   logic [OffsetWidth-1:0] start_in, span_in;
   logic [RecipWidth-1:0]  recip_in;
   chan_cfg_type           cfg_in [Chans];
   logic [OffsetWidth-1:0] off1_in;

   logic [OffsetWidth-1:0] off1_ff, span1_ff, span2_ff, span3_ff, span4_ff;
   logic [RecipWidth-1:0]  recip1_ff, recip2_ff;
   chan_cfg_type           cfg1_ff [Chans];
   logic [NumWidth-1:0]    num2_ff [Chans], num3_ff [Chans], num4_ff [Chans];
   logic [NumWidth-1:0]    num2_in [Chans];
   logic [ColourWidth-1:0] base2_ff [Chans], base3_ff [Chans], base4_ff [Chans];
   logic                   neg2_ff [Chans], neg3_ff [Chans], neg4_ff [Chans];
   logic [ProdWidth-1:0]   prod3_ff [Chans], prod3_in [Chans];
   logic [QuotWidth-1:0]   quot4_ff [Chans], quot4_in [Chans];
   logic [QdWidth-1:0]     qd4_ff [Chans], qd4_in [Chans];
   logic [ColourWidth-1:0] col5_ff [Chans], col5_in [Chans];

   // Segment selection: start, span, reciprocal and per-channel lines.
   always_comb begin
      if (reading < ReadingWidth'(10)) begin
         start_in = '0;   span_in = Span500;  recip_in = Recip500;
         cfg_in[0] = chan(8'd0, 8'd0, 1'b0);
         cfg_in[1] = chan(8'd0, 8'd0, 1'b0);
         cfg_in[2] = chan(8'd250, 8'd0, 1'b0);
      end else if (reading < ReadingWidth'(500)) begin
         start_in = '0;   span_in = Span500;  recip_in = Recip500;
         cfg_in[0] = chan(8'd0, 8'd100, 1'b0);
         cfg_in[1] = chan(8'd0, 8'd100, 1'b0);
         cfg_in[2] = chan(8'd200, 8'd100, 1'b1);
      end else if (reading < ReadingWidth'(1900)) begin
         start_in = OffsetWidth'(500);  span_in = Span1400; recip_in = Recip1400;
         cfg_in[0] = chan(8'd100, 8'd50, 1'b0);
         cfg_in[1] = chan(8'd100, 8'd50, 1'b0);
         cfg_in[2] = chan(8'd100, 8'd20, 1'b0);
      end else if (reading < ReadingWidth'(1970)) begin
         start_in = OffsetWidth'(1900); span_in = Span70;   recip_in = Recip70;
         cfg_in[0] = chan(8'd100, 8'd68, 1'b1);
         cfg_in[1] = chan(8'd200, 8'd55, 1'b0);
         cfg_in[2] = chan(8'd80, 8'd80, 1'b1);
      end else if (reading < ReadingWidth'(1990)) begin
         start_in = OffsetWidth'(1970); span_in = Span20;   recip_in = Recip20;
         cfg_in[0] = chan(8'd0, 8'd70, 1'b0);
         cfg_in[1] = chan(8'd255, 8'd0, 1'b0);
         cfg_in[2] = chan(8'd0, 8'd0, 1'b0);
      end else if (reading < ReadingWidth'(2100)) begin
         start_in = OffsetWidth'(1990); span_in = Span110;  recip_in = Recip110;
         cfg_in[0] = chan(8'd70, 8'd185, 1'b0);
         cfg_in[1] = chan(8'd255, 8'd255, 1'b1);
         cfg_in[2] = chan(8'd0, 8'd0, 1'b0);
      end else begin
         // Solid red: zero slopes make the offset irrelevant.
         start_in = '0;   span_in = Span500;  recip_in = Recip500;
         cfg_in[0] = chan(8'd255, 8'd0, 1'b0);
         cfg_in[1] = chan(8'd0, 8'd0, 1'b0);
         cfg_in[2] = chan(8'd0, 8'd0, 1'b0);
      end
      off1_in = OffsetWidth'(reading - ReadingWidth'(start_in));
   end

   // Per-channel arithmetic of stages two to five.
   always_comb begin
      logic [OffsetWidth+ColourWidth-1:0] wide;
      logic [QdWidth-1:0]                 rem;
      logic [QuotWidth-1:0]               quot;
      logic [QuotWidth+1:0]               sum;
      for (int c = 0; c < Chans; c++) begin
         // Offset times slope magnitude.
         wide       = (OffsetWidth+ColourWidth)'(off1_ff) * cfg1_ff[c].step;
         num2_in[c] = wide[NumWidth-1:0];

         // Quotient estimate by reciprocal, at most one short.
         prod3_in[c] = ProdWidth'(num2_ff[c]) * ProdWidth'(recip2_ff);
         quot4_in[c] = prod3_ff[c][ProdWidth-1:RecipShift];
         qd4_in[c]   = QdWidth'(quot4_in[c]) * QdWidth'(span3_ff);

         // Correct the estimate, apply the sign and the base, then clamp.
         rem  = QdWidth'(num4_ff[c]) - qd4_ff[c];
         quot = (rem >= QdWidth'(span4_ff)) ? quot4_ff[c] + QuotWidth'(1) : quot4_ff[c];
         if (neg4_ff[c]) begin
            sum = (QuotWidth+2)'(base4_ff[c]) - (QuotWidth+2)'(quot);
         end else begin
            sum = (QuotWidth+2)'(base4_ff[c]) + (QuotWidth+2)'(quot);
         end
         if (sum[QuotWidth+1]) begin
            col5_in[c] = '0;
         end else if (sum[QuotWidth:ColourWidth] != '0) begin
            col5_in[c] = '1;
         end else begin
            col5_in[c] = sum[ColourWidth-1:0];
         end
      end
   end

   // Pipeline registers, moved together whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         off1_ff   <= off1_in;
         span1_ff  <= span_in;
         recip1_ff <= recip_in;
         span2_ff  <= span1_ff;
         recip2_ff <= recip1_ff;
         span3_ff  <= span2_ff;
         span4_ff  <= span3_ff;
         for (int c = 0; c < Chans; c++) begin
            cfg1_ff[c]  <= cfg_in[c];
            num2_ff[c]  <= num2_in[c];
            base2_ff[c] <= cfg1_ff[c].base;
            neg2_ff[c]  <= cfg1_ff[c].neg;
            prod3_ff[c] <= prod3_in[c];
            num3_ff[c]  <= num2_ff[c];
            base3_ff[c] <= base2_ff[c];
            neg3_ff[c]  <= neg2_ff[c];
            quot4_ff[c] <= quot4_in[c];
            qd4_ff[c]   <= qd4_in[c];
            num4_ff[c]  <= num3_ff[c];
            base4_ff[c] <= base3_ff[c];
            neg4_ff[c]  <= neg3_ff[c];
            col5_ff[c]  <= col5_in[c];
         end
      end
   end

   assign colour.red   = col5_ff[0];
   assign colour.green = col5_ff[1];
   assign colour.blue  = col5_ff[2];

endmodule

FILE: design/vled_gamma.sv
// ----------------------------------------------------------------------------
// Voltage LED meter gamma stage
// Half-strength gamma on each channel and the derived backlight colour,
// registered as the output stage.
// ----------------------------------------------------------------------------
module vled_gamma
   import vled_pkg::*;
(
   input  logic    clock,
   input  logic    advance,
   input  rgb_type colour,
   output rgb_type segment,
   output rgb_type backlight
);

   // Average of the channel and its gamma-2.8 value, truncated.
   function automatic logic [ColourWidth-1:0] half_gamma(input logic [ColourWidth-1:0] c);
      logic [ColourWidth:0] sum;
      sum = {1'b0, c} + {1'b0, Gamma28[c]};
      return sum[ColourWidth:1];
   endfunction

   // Backlight is the corrected channel halved, lifted by 64.
   function automatic logic [ColourWidth-1:0] back_of(input logic [ColourWidth-1:0] c);
      return {1'b0, c[ColourWidth-1:1]} + ColourWidth'(64);
   endfunction

   rgb_type seg_ff, seg_in, back_ff, back_in;

   always_comb begin
      seg_in.red    = half_gamma(colour.red);
      seg_in.green  = half_gamma(colour.green);
      seg_in.blue   = half_gamma(colour.blue);
      back_in.red   = back_of(seg_in.red);
      back_in.green = back_of(seg_in.green);
      back_in.blue  = back_of(seg_in.blue);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_ff  <= seg_in;
         back_ff <= back_in;
      end
   end

   assign segment   = seg_ff;
   assign backlight = back_ff;

endmodule

FILE: design/voltage_to_led_meter_display_unit.sv
// An accepted request passes through the six register stages to its response.
// Throughput: one request per cycle; the six-stage pipeline advances as a
// whole whenever its last stage is empty or the response is being taken.
// Reset (synchronous, active high) clears all stage valid bits; the data
// registers are not reset.
// ----------------------------------------------------------------------------
// Voltage LED meter display unit
// Turns a voltage reading into four blanked decimal digits, a gamma-corrected
// segment colour from a piecewise-linear ramp, and a backlight colour.
// ----------------------------------------------------------------------------
module voltage_to_led_meter_display_unit
   import vled_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ReadingWidth-1:0] req_reading,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DigitWidth-1:0]   rsp_digit_thousands,
   output logic [DigitWidth-1:0]   rsp_digit_hundreds,
   output logic [DigitWidth-1:0]   rsp_digit_tens,
   output logic [DigitWidth-1:0]   rsp_digit_ones,
   output logic [DigitWidth-1:0]   rsp_blank_mask,
   output logic [ColourWidth-1:0]  rsp_red,
   output logic [ColourWidth-1:0]  rsp_green,
   output logic [ColourWidth-1:0]  rsp_blue,
   output logic [ColourWidth-1:0]  rsp_back_red,
   output logic [ColourWidth-1:0]  rsp_back_green,
   output logic [ColourWidth-1:0]  rsp_back_blue
);

   logic [PipeDepth-1:0] vld_ff, vld_in;
   logic                 advance;
   rgb_type              colour, segment, backlight;

   // The whole pipeline moves unless a finished request waits at the output.
   assign advance   = !vld_ff[PipeDepth-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[PipeDepth-1];

   // Valid bits travel alongside the data stages.
   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[PipeDepth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   vled_digits u_digits (
      .clock           (clock),
      .advance         (advance),
      .reading         (req_reading),
      .digit_thousands (rsp_digit_thousands),
      .digit_hundreds  (rsp_digit_hundreds),
      .digit_tens      (rsp_digit_tens),
      .digit_ones      (rsp_digit_ones),
      .blank_mask      (rsp_blank_mask)
   );

   vled_ramp u_ramp (
      .clock   (clock),
      .advance (advance),
      .reading (req_reading),
      .colour  (colour)
   );

   vled_gamma u_gamma (
      .clock     (clock),
      .advance   (advance),
      .colour    (colour),
      .segment   (segment),
      .backlight (backlight)
   );

   assign rsp_red        = segment.red;
   assign rsp_green      = segment.green;
   assign rsp_blue       = segment.blue;
   assign rsp_back_red   = backlight.red;
   assign rsp_back_green = backlight.green;
   assign rsp_back_blue  = backlight.blue;

endmodule

FILE: tb/sv/voltage_to_led_meter_display_unit_test.sv
// ----------------------------------------------------------------------------
// Voltage LED meter display unit testbench
// Drives readings into the meter display unit under bursty request traffic
// and a stalling response side. Each response is checked field by field
// against a predictor of the digits, blanking, ramp colour and backlight.
// ----------------------------------------------------------------------------
module voltage_to_led_meter_display_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vled_pkg::*;

   localparam int RandomCount  = 1785;
   localparam int StallCount   = 40;
   localparam int HoldCycles   = 300;
   localparam int DrainLimit   = 5000;
   localparam int SettleCycles = PipeDepth * 4;
   localparam int TimeoutNs    = 5_000_000;
   localparam int ReportLimit  = 10;
   localparam int ReadingLimit = 9999;

   // Ways in which the response side takes or refuses responses.
   typedef enum logic [1:0] {
      TakeAll,
      TakeHalf,
      TakeMost,
      TakeFew
   } take_pattern_type;

   // Everything the display shows for one reading.
   typedef struct {
      logic [ReadingWidth-1:0] reading;
      logic [DigitWidth-1:0]   thousands;
      logic [DigitWidth-1:0]   hundreds;
      logic [DigitWidth-1:0]   tens;
      logic [DigitWidth-1:0]   ones;
      logic [DigitWidth-1:0]   blank;
      logic [ColourWidth-1:0]  red;
      logic [ColourWidth-1:0]  green;
      logic [ColourWidth-1:0]  blue;
      logic [ColourWidth-1:0]  back_red;
      logic [ColourWidth-1:0]  back_green;
      logic [ColourWidth-1:0]  back_blue;
   } meter_view_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ReadingWidth-1:0] req_reading = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DigitWidth-1:0]   rsp_digit_thousands;
   logic [DigitWidth-1:0]   rsp_digit_hundreds;
   logic [DigitWidth-1:0]   rsp_digit_tens;
   logic [DigitWidth-1:0]   rsp_digit_ones;
   logic [DigitWidth-1:0]   rsp_blank_mask;
   logic [ColourWidth-1:0]  rsp_red;
   logic [ColourWidth-1:0]  rsp_green;
   logic [ColourWidth-1:0]  rsp_blue;
   logic [ColourWidth-1:0]  rsp_back_red;
   logic [ColourWidth-1:0]  rsp_back_green;
   logic [ColourWidth-1:0]  rsp_back_blue;

   meter_view_type   expected_views[$];
   int               fault_count  = 0;
   int               burst_left   = 0;
   int               hold_left    = 0;
   int               pattern_left = 0;
   take_pattern_type pattern      = TakeAll;

   voltage_to_led_meter_display_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_reading         (req_reading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit_thousands (rsp_digit_thousands),
      .rsp_digit_hundreds  (rsp_digit_hundreds),
      .rsp_digit_tens      (rsp_digit_tens),
      .rsp_digit_ones      (rsp_digit_ones),
      .rsp_blank_mask      (rsp_blank_mask),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_back_red        (rsp_back_red),
      .rsp_back_green      (rsp_back_green),
      .rsp_back_blue       (rsp_back_blue)
   );

   // Free-running clock, 20 ns period.
   initial begin
      forever #10 clock = ~clock;
   end

   // Straight line through one ramp segment; division truncates toward zero.
   function automatic int ramp_point(int v, int lo, int hi, int start_level, int end_level);
      return start_level + (v - lo) * (end_level - start_level) / (hi - lo);
   endfunction

   // Half-strength gamma: the channel averaged with its gamma-2.8 value.
   function automatic logic [ColourWidth-1:0] soften(int level);
      int c;
      c = (level < 0) ? 0 : ((level > 255) ? 255 : level);
      return ColourWidth'((c + int'(Gamma28[c])) / 2);
   endfunction

   // Works out the full display for one reading.
   function automatic meter_view_type predict_view(logic [ReadingWidth-1:0] value);
      meter_view_type view;
      int          v;
      int          r;
      int          g;
      int          b;
      int          rest;
      int          place;
      int          digit [4];
      bit          seen;
      v = int'(value);
      if (v < 10) begin
         r = 0; g = 0; b = 250;
      end else if (v < 500) begin
         r = ramp_point(v, 0, 500, 0, 100); g = r;
         b = ramp_point(v, 0, 500, 200, 100);
      end else if (v < 1900) begin
         r = ramp_point(v, 500, 1900, 100, 150); g = r;
         b = ramp_point(v, 500, 1900, 100, 120);
      end else if (v < 1970) begin
         r = ramp_point(v, 1900, 1970, 100, 32);
         g = ramp_point(v, 1900, 1970, 200, 255);
         b = ramp_point(v, 1900, 1970, 80, 0);
      end else if (v < 1990) begin
         r = ramp_point(v, 1970, 1990, 0, 70); g = 255; b = 0;
      end else if (v < 2100) begin
         r = ramp_point(v, 1990, 2100, 70, 255);
         g = ramp_point(v, 1990, 2100, 255, 0); b = 0;
      end else begin
         r = 255; g = 0; b = 0;
      end
      view.reading    = value;
      view.red        = soften(r);
      view.green      = soften(g);
      view.blue       = soften(b);
      view.back_red   = (view.red >> 1) + 8'd64;
      view.back_green = (view.green >> 1) + 8'd64;
      view.back_blue  = (view.blue >> 1) + 8'd64;

      // Readings past the four digits saturate to all nines.
      rest  = (v > ReadingLimit) ? ReadingLimit : v;
      place = 1000;
      seen  = 1'b0;
      view.blank = '0;
      for (int k = 0; k < 4; k++) begin
         digit[k] = rest / place;
         rest     = rest - digit[k] * place;
         place    = place / 10;
         if (digit[k] != 0) begin
            seen = 1'b1;
         end else if (!seen) begin
            view.blank[3-k] = 1'b1;
         end
      end
      view.thousands = DigitWidth'(digit[0]);
      view.hundreds  = DigitWidth'(digit[1]);
      view.tens      = DigitWidth'(digit[2]);
      view.ones      = DigitWidth'(digit[3]);
      return view;
   endfunction

   // Random reading, weighted toward the ramp, its breakpoints and short numbers, some above range.
   function automatic logic [ReadingWidth-1:0] pick_reading();
      int breakpoints [7] = '{10, 500, 1900, 1970, 1990, 2100, 10000};
      int choice;
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
         return ReadingWidth'($urandom_range(0, 2199));
      end else if (choice < 60) begin
         return ReadingWidth'(breakpoints[$urandom_range(0, 6)]
                              + int'($urandom_range(0, 6)) - 3);
      end else if (choice < 73) begin
         return ReadingWidth'($urandom_range(0, ReadingLimit));
      end else if (choice < 80) begin
         return ReadingWidth'($urandom_range(0, 99));
      end else if (choice < 88) begin
         return ReadingWidth'($urandom_range(0, 999));
      end
      return ReadingWidth'($urandom_range(ReadingLimit + 1, (1 << ReadingWidth) - 1));
   endfunction

   task automatic report_fault(input string text);
      fault_count++;
      if (fault_count <= ReportLimit) begin
         $display("ERROR at %0t ns: %s", $time, text);
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got, input logic [ReadingWidth-1:0] value);
      if (got !== want) begin
         report_fault($sformatf("reading %0d: %s expected %0d, got %0d",
                                value, name, want, got));
      end
   endtask

   // Offers one request, in bursts with random gaps, and records what it
   // should show once it is taken. Returns on the rising edge of acceptance.
   task automatic send_reading(input logic [ReadingWidth-1:0] value);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_reading <= value;
      do begin
         @(posedge clock);
      end while (!req_ready);
      expected_views.push_back(predict_view(value));
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Breakpoints, digit blanking, saturation above range and both ends of
   // the reading field.
   task automatic test_directed_readings();
      int readings [25] = '{0, 1, 9, 10, 11, 100, 250, 499, 500, 501, 1000, 1200,
                            1899, 1900, 1935, 1969, 1970, 1989, 1990, 2045, 2099,
                            2100, 9999, 10000, 16383};
      foreach (readings[i]) begin
         send_reading(ReadingWidth'(readings[i]));
      end
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming, so the pipeline fills and stalls its input.
   task automatic test_output_stall();
      // Called on the rising edge of the last acceptance, clear of the
      // response process on the falling edge.
      hold_left = HoldCycles;
      repeat (StallCount) send_reading(pick_reading());
   endtask

   task automatic test_random_readings();
      repeat (RandomCount) send_reading(pick_reading());
   endtask

   // Response side: a long hold when asked for one, otherwise a changing
   // pattern of stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern      = take_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 128);
         end
         pattern_left = pattern_left - 1;
         case (pattern)
            TakeAll:  rsp_ready <= 1'b1;
            TakeHalf: rsp_ready <= 1'($urandom_range(0, 1));
            TakeMost: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:  rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Each response taken is checked against the oldest outstanding request.
   always @(posedge clock) begin
      meter_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_views.size() == 0) begin
            report_fault($sformatf("response with no request outstanding (digits %0d%0d%0d%0d)",
                                   rsp_digit_thousands, rsp_digit_hundreds,
                                   rsp_digit_tens, rsp_digit_ones));
         end else begin
            want = expected_views.pop_front();
            compare_field("digit_thousands", want.thousands, rsp_digit_thousands, want.reading);
            compare_field("digit_hundreds", want.hundreds, rsp_digit_hundreds, want.reading);
            compare_field("digit_tens", want.tens, rsp_digit_tens, want.reading);
            compare_field("digit_ones", want.ones, rsp_digit_ones, want.reading);
            compare_field("blank_mask", want.blank, rsp_blank_mask, want.reading);
            compare_field("red", want.red, rsp_red, want.reading);
            compare_field("green", want.green, rsp_green, want.reading);
            compare_field("blue", want.blue, rsp_blue, want.reading);
            compare_field("back_red", want.back_red, rsp_back_red, want.reading);
            compare_field("back_green", want.back_green, rsp_back_green, want.reading);
            compare_field("back_blue", want.back_blue, rsp_back_blue, want.reading);
         end
      end
   end

   // Guard against a hung run.
   initial begin
      #(TimeoutNs);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Test sequence.
   initial begin
      int drain_cycles;
      drain_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_readings();
      test_output_stall();
      test_random_readings();
      drop_request();

      // Let the outstanding responses come out, then watch for stray ones.
      while (expected_views.size() != 0 && drain_cycles < DrainLimit) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (expected_views.size() != 0) begin
         report_fault($sformatf("%0d responses never arrived", expected_views.size()));
      end

      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
